// ===== src/fsdt_pkg.sv =====
// Package for the frame second difference threshold unit.
// Holds the sizes, payload types and divider constants shared by all files.
// No dependencies.
package fsdt_pkg;

  // Frame length in samples and depth of the moving window.
  localparam int FRAME_LEN = 41;
  localparam int WINDOW    = 26;

  localparam int SAMPLE_W   = 12;
  localparam int DIFF_W     = SAMPLE_W + 1;
  localparam int DSIGNED_W  = SAMPLE_W + 2;
  localparam int FRAME_CELLS = 2 * FRAME_LEN;
  localparam int POS_W      = $clog2(FRAME_LEN);
  localparam int SUM_W      = DIFF_W + $clog2(WINDOW + 1);

  // Division by WINDOW is a multiplication by a rounded-up reciprocal.
  // The rounding error stays below WINDOW, so DIV_SHIFT = SUM_W + 6 keeps
  // the product exact for every reachable window sum.
  localparam int DIV_SHIFT = SUM_W + 6;
  localparam int MULT_W    = DIV_SHIFT + 1;
  localparam int PROD_W    = SUM_W + MULT_W;
  localparam logic [MULT_W-1:0] DIV_MULT =
    MULT_W'((2 ** DIV_SHIFT + WINDOW - 1) / WINDOW);

  localparam int NUM_SLOTS = 5;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int THR_SUM_W = DIFF_W + 2;

  typedef logic [SAMPLE_W-1:0]  sample_t;
  typedef logic [DIFF_W-1:0]    diff_t;
  typedef logic [SUM_W-1:0]     sum_t;
  typedef logic [PROD_W-1:0]    prod_t;
  typedef logic [POS_W-1:0]     pos_t;
  typedef logic [SLOT_W-1:0]    slot_ptr_t;

endpackage

// ===== src/fsdt_sample_if.sv =====
// Handshake channel interfaces of the frame second difference threshold unit.
// Depends on fsdt_pkg for the payload types.
interface fsdt_sample_if;
  import fsdt_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface fsdt_result_if;
  import fsdt_pkg::*;
  logic  valid;
  logic  ready;
  diff_t difference;
  diff_t window_mean;
  diff_t threshold;
  logic  frame_end;
  modport source (output valid, output difference, output window_mean,
                  output threshold, output frame_end, input ready);
  modport sink (input valid, input difference, input window_mean,
                input threshold, input frame_end, output ready);
endinterface

// ===== src/frame_second_difference_threshold_unit.sv =====
// Top level of the frame second difference threshold unit.
// Depends on fsdt_pkg, fsdt_sample_if, fsdt_result_if, fsdt_frame_cell
// and fsdt_window_cell.
//
//   Channel  Dir  Carries                                         Handshake
//   smp_i    in   sample                                          valid/ready
//   res_o    out  difference, window_mean, threshold, frame_end   valid/ready
//
// One sample is accepted per cycle while the pipeline is not stalled; its
// result passes through the four pipeline registers (difference, window sum,
// reciprocal product, output). Each stage holds while the one after it is
// full and cannot move on, so a stall on res_o fills the pipeline before
// smp_i drops ready. Reset clears the delay line, the window, the running
// sum and the mean slots at once; the first transaction can follow immediately.
module frame_second_difference_threshold_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  fsdt_sample_if.sink     smp_i,
  fsdt_result_if.source   res_o
);
  import fsdt_pkg::*;

  // Pipeline occupancy and the ready chain. A stage can load when it is
  // empty or when its content moves on in the same cycle.
  logic v1_q, v2_q, v3_q, v4_q;
  logic take1, take2, take3, take4;
  logic smp_accept, load2, load3, load4;

  assign take4 = !v4_q || res_o.ready;
  assign take3 = !v3_q || take4;
  assign take2 = !v2_q || take3;
  assign take1 = !v1_q || take2;

  assign smp_i.ready = take1;
  assign smp_accept  = smp_i.valid && take1;
  assign load2       = v1_q && take2;
  assign load3       = v2_q && take3;
  assign load4       = v3_q && take4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (take1) v1_q <= smp_i.valid;
      if (take2) v2_q <= v1_q;
      if (take3) v3_q <= v2_q;
      if (take4) v4_q <= v3_q;
    end
  end

  // Sample delay line. Rotating three frame stores is the same as looking
  // back one and two frames in the sample stream, so a chain of two frames
  // of cells supplies the previous and second previous samples at the
  // same position in the frame.
  sample_t frame_tap [FRAME_CELLS];

  for (genvar i = 0; i < FRAME_CELLS; i++) begin : g_frame
    if (i == 0) begin : g_head
      fsdt_frame_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (smp_accept),
        .data_i  (smp_i.sample),
        .data_o  (frame_tap[i])
      );
    end else begin : g_body
      fsdt_frame_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (smp_accept),
        .data_i  (frame_tap[i-1]),
        .data_o  (frame_tap[i])
      );
    end
  end

  // Position within the frame marks the last sample of each frame.
  pos_t pos_q, pos_d;
  logic frame_last;

  assign frame_last = (pos_q == POS_W'(FRAME_LEN - 1));
  assign pos_d      = frame_last ? '0 : pos_q + POS_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (smp_accept) begin
      pos_q <= pos_d;
    end
  end

  // Stage 1: second difference, current - 2*previous + second previous.
  // A negative result is folded by complement, which gives magnitude - 1.
  logic signed [DSIGNED_W-1:0] second_diff;
  diff_t diff_fold;

  assign second_diff = $signed({2'b00, smp_i.sample})
                     - $signed({1'b0, frame_tap[FRAME_LEN-1], 1'b0})
                     + $signed({2'b00, frame_tap[FRAME_CELLS-1]});
  assign diff_fold   = second_diff[DSIGNED_W-1] ? ~second_diff[DIFF_W-1:0]
                                                :  second_diff[DIFF_W-1:0];

  diff_t diff1_q;
  logic  last1_q;

  always_ff @(posedge clk_i) begin
    if (smp_accept) begin
      diff1_q <= diff_fold;
      last1_q <= frame_last;
    end
  end

  // Stage 2: moving window. The oldest value drops out of the running sum
  // as the new difference enters the head of the window chain.
  diff_t win_tap [WINDOW];

  for (genvar j = 0; j < WINDOW; j++) begin : g_window
    if (j == 0) begin : g_head
      fsdt_window_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (load2),
        .data_i  (diff1_q),
        .data_o  (win_tap[j])
      );
    end else begin : g_body
      fsdt_window_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (load2),
        .data_i  (win_tap[j-1]),
        .data_o  (win_tap[j])
      );
    end
  end

  sum_t win_sum_q, win_sum_d;

  assign win_sum_d = win_sum_q - SUM_W'(win_tap[WINDOW-1]) + SUM_W'(diff1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_sum_q <= '0;
    end else if (load2) begin
      win_sum_q <= win_sum_d;
    end
  end

  sum_t  sum2_q;
  diff_t diff2_q;
  logic  last2_q;

  always_ff @(posedge clk_i) begin
    if (load2) begin
      sum2_q  <= win_sum_d;
      diff2_q <= diff1_q;
      last2_q <= last1_q;
    end
  end

  // Stage 3: the window sum times the reciprocal of the window depth.
  prod_t prod3_q, prod_d;
  diff_t diff3_q;
  logic  last3_q;

  assign prod_d = PROD_W'(sum2_q) * PROD_W'(DIV_MULT);

  always_ff @(posedge clk_i) begin
    if (load3) begin
      prod3_q <= prod_d;
      diff3_q <= diff2_q;
      last3_q <= last2_q;
    end
  end

  // Stage 4: the mean enters the slot rotation. The threshold averages
  // slots one, two, four and five after this mean is stored; slot three is
  // written but takes no part.
  diff_t     mean;
  diff_t     slot_q   [NUM_SLOTS];
  diff_t     slot_nxt [NUM_SLOTS];
  slot_ptr_t slot_ptr_q, slot_ptr_d;
  logic [THR_SUM_W-1:0] thr_sum;

  assign mean = prod3_q[DIV_SHIFT +: DIFF_W];

  always_comb begin
    for (int k = 0; k < NUM_SLOTS; k++) begin
      slot_nxt[k] = (slot_ptr_q == SLOT_W'(k)) ? mean : slot_q[k];
    end
  end

  assign slot_ptr_d = (slot_ptr_q == SLOT_W'(NUM_SLOTS - 1)) ? '0
                                                             : slot_ptr_q + SLOT_W'(1);
  assign thr_sum = THR_SUM_W'(slot_nxt[0]) + THR_SUM_W'(slot_nxt[1])
                 + THR_SUM_W'(slot_nxt[3]) + THR_SUM_W'(slot_nxt[4]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_ptr_q <= '0;
      for (int k = 0; k < NUM_SLOTS; k++) begin
        slot_q[k] <= '0;
      end
    end else if (load4) begin
      slot_ptr_q <= slot_ptr_d;
      for (int k = 0; k < NUM_SLOTS; k++) begin
        slot_q[k] <= slot_nxt[k];
      end
    end
  end

  // Output register; it holds the finished result while res_o stalls.
  diff_t diff4_q, mean4_q, thr4_q;
  logic  last4_q;

  always_ff @(posedge clk_i) begin
    if (load4) begin
      diff4_q <= diff3_q;
      mean4_q <= mean;
      thr4_q  <= thr_sum[THR_SUM_W-1:2];
      last4_q <= last3_q;
    end
  end

  assign res_o.valid       = v4_q;
  assign res_o.difference  = diff4_q;
  assign res_o.window_mean = mean4_q;
  assign res_o.threshold   = thr4_q;
  assign res_o.frame_end   = last4_q;

endmodule

// ===== src/fsdt_frame_cell.sv =====
// One cell of the sample delay line that spans two frames.
// Depends on fsdt_pkg for the sample type.
module fsdt_frame_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  fsdt_pkg::sample_t data_i,
  output fsdt_pkg::sample_t data_o
);
  import fsdt_pkg::*;

  sample_t data_q;

  // Frames that have not arrived yet read as zero samples.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else if (shift_i) begin
      data_q <= data_i;
    end
  end

  assign data_o = data_q;
endmodule

// ===== src/fsdt_window_cell.sv =====
// One cell of the moving window of folded differences.
// Depends on fsdt_pkg for the difference type.
module fsdt_window_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           shift_i,
  input  fsdt_pkg::diff_t data_i,
  output fsdt_pkg::diff_t data_o
);
  import fsdt_pkg::*;

  diff_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else if (shift_i) begin
      data_q <= data_i;
    end
  end

  assign data_o = data_q;
endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for frame_second_difference_threshold_unit.
// Depends on fsdt_pkg, the fsdt_sample_if and fsdt_result_if interfaces,
// and the unit's RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fsdt_pkg::*;

  // One expected or observed result transaction.
  typedef struct packed {
    diff_t difference;
    diff_t window_mean;
    diff_t threshold;
    logic  frame_end;
  } outcome_t;

  // Shapes of the random frames. The flip pattern alternates all-zero and
  // all-full frames, which drives the second difference to both extremes.
  typedef enum int {
    PAT_UNIFORM,
    PAT_FLIP_EXTREME,
    PAT_SCATTER_EXTREME,
    PAT_NEAR_BASE
  } frame_pattern_e;

  localparam int RANDOM_ITEMS = 925;
  localparam int QUIET_FROM   = 775;
  localparam int HOLD_AT      = 250;
  localparam int DRAIN_AT     = 500;

  // Predicts the second-difference threshold unit and matches its results.
  class threshold_scoreboard;
    sample_t     frame_mem[3][FRAME_LEN];
    diff_t       win_vals[WINDOW];
    diff_t       mean_slot[NUM_SLOTS];
    int unsigned active_frame, frame_pos, win_pos, win_total, slot_idx;
    outcome_t    pending_q[$];
    int unsigned mismatches, results_seen, samples_seen, peak_diff, peak_thr;

    function new();
      foreach (frame_mem[i, j]) frame_mem[i][j] = '0;
      foreach (win_vals[i]) win_vals[i] = '0;
      foreach (mean_slot[i]) mean_slot[i] = '0;
      active_frame = 0;
      frame_pos    = 0;
      win_pos      = 0;
      win_total    = 0;
      slot_idx     = 0;
      mismatches   = 0;
      results_seen = 0;
      samples_seen = 0;
      peak_diff    = 0;
      peak_thr     = 0;
    endfunction

    // Works out the result of one accepted sample and queues it.
    function void note_sample(sample_t s);
      int          d;
      int unsigned mag, avg;
      outcome_t    o;
      frame_mem[active_frame][frame_pos] = s;
      // Previous frame sits one store behind the active one, the frame
      // before that two stores behind.
      d = int'(s) - 2 * int'(frame_mem[(active_frame + 2) % 3][frame_pos])
          + int'(frame_mem[(active_frame + 1) % 3][frame_pos]);
      // Negative values fold by complement, so they come out one short.
      mag = (d >= 0) ? d : -d - 1;
      o.difference = diff_t'(mag);
      win_total = win_total - win_vals[win_pos] + mag;
      win_vals[win_pos] = diff_t'(mag);
      win_pos = (win_pos + 1) % WINDOW;
      o.window_mean = diff_t'(win_total / WINDOW);
      mean_slot[slot_idx] = o.window_mean;
      slot_idx = (slot_idx + 1) % NUM_SLOTS;
      // The third slot is written but left out of the average.
      avg = (int'(mean_slot[0]) + int'(mean_slot[1]) + int'(mean_slot[3])
             + int'(mean_slot[4])) / 4;
      o.threshold = diff_t'(avg);
      o.frame_end = (frame_pos == FRAME_LEN - 1);
      if (o.frame_end) begin
        frame_pos    = 0;
        active_frame = (active_frame + 1) % 3;
      end else begin
        frame_pos++;
      end
      if (mag > peak_diff) peak_diff = mag;
      if (avg > peak_thr) peak_thr = avg;
      pending_q.push_back(o);
      samples_seen++;
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        $display("%0.3f ns: %s mismatch, expected %0d, actual %0d",
                 $realtime, name, want, got);
      end
    endfunction

    // Compares one result transaction with the oldest expectation.
    function void check_result(outcome_t got);
      outcome_t want;
      if (pending_q.size() == 0) begin
        mismatches++;
        $display("%0.3f ns: result with nothing expected, expected none, actual %0d/%0d/%0d/%0d",
                 $realtime, got.difference, got.window_mean, got.threshold, got.frame_end);
      end else begin
        want = pending_q.pop_front();
        compare_field("difference", want.difference, got.difference);
        compare_field("window_mean", want.window_mean, got.window_mean);
        compare_field("threshold", want.threshold, got.threshold);
        compare_field("frame_end", want.frame_end, got.frame_end);
      end
      results_seen++;
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  fsdt_sample_if smp ();
  fsdt_result_if res ();

  frame_second_difference_threshold_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .smp_i  (smp),
    .res_o  (res)
  );

  always #6 clk_i = ~clk_i;

  threshold_scoreboard sb = new();

  // Idling controls shared between the sender, the receiver and the
  // sequence in the main process.
  bit src_idle_on  = 1'b0;
  bit sink_idle_on = 1'b0;
  bit hold_request = 1'b0;

  // Stimulus bookkeeping: index of the next sample offered and the
  // pattern of the frame it falls in.
  int unsigned    stim_index  = 0;
  frame_pattern_e pattern     = PAT_UNIFORM;
  int unsigned    frames_left = 0;
  bit             first_run   = 1'b1;
  sample_t        flip_level  = '0;
  int             near_base   = 0;

  // Both channels are observed at the rising edge. Inputs only change at
  // the falling edge, so the values seen here are settled.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (smp.valid && smp.ready) sb.note_sample(smp.sample);
      if (res.valid && res.ready)
        sb.check_result('{res.difference, res.window_mean, res.threshold, res.frame_end});
    end
  end

  // Receiver: short random stalls, plus one long hold-off on request that
  // lets the pipeline fill up and push back on the sample channel.
  initial begin : result_sink
    int unsigned hold_len;
    res.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_len = $urandom_range(30, 50);
        res.ready <= 1'b0;
        repeat (hold_len - 1) @(negedge clk_i);
      end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(0, 2)) @(negedge clk_i);
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  // Offers one sample and holds it until the unit takes it. A random idle
  // burst may follow the transaction.
  task automatic send_sample(sample_t s);
    int unsigned gap;
    @(negedge clk_i);
    smp.valid  <= 1'b1;
    smp.sample <= s;
    do @(posedge clk_i); while (!smp.ready);
    stim_index++;
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      @(negedge clk_i);
      smp.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Drops valid and waits until every queued result has come back.
  task automatic drain_results();
    @(negedge clk_i);
    smp.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  // Picks the next random sample. Frames come in runs of a few frames
  // sharing one pattern; the first run always alternates extreme frames.
  function automatic sample_t pick_sample();
    int v;
    if (stim_index % FRAME_LEN == 0) begin
      if (frames_left == 0) begin
        if (first_run) begin
          pattern     = PAT_FLIP_EXTREME;
          frames_left = 4;
          first_run   = 1'b0;
        end else begin
          pattern     = frame_pattern_e'($urandom_range(0, 3));
          frames_left = $urandom_range(2, 4);
        end
      end
      frames_left--;
      flip_level = ~flip_level;
      near_base  = $urandom_range(0, 4095);
    end
    case (pattern)
      PAT_FLIP_EXTREME:    return flip_level;
      PAT_SCATTER_EXTREME: return $urandom_range(0, 1) ? '1 : '0;
      PAT_NEAR_BASE: begin
        v = near_base + int'($urandom_range(0, 64)) - 32;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return sample_t'(v);
      end
      default:             return sample_t'($urandom_range(0, 4095));
    endcase
  endfunction

  // Directed opening: field extremes, single bits and checkerboards. These
  // land in the first frame, where both older frames still read as zero.
  sample_t directed_samples[25] = '{
    12'h000, 12'hFFF, 12'h000, 12'hFFF, 12'hAAA, 12'h555, 12'h001, 12'h800,
    12'h7FF, 12'hFFE, 12'h002, 12'h004, 12'h008, 12'h010, 12'h020, 12'h040,
    12'h080, 12'h100, 12'h200, 12'h400, 12'hFFF, 12'hFFF, 12'h000, 12'h000,
    12'hFFF
  };

  initial begin : main_sequence
    smp.valid  = 1'b0;
    smp.sample = '0;
    rst_ni     = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_samples[i]) send_sample(directed_samples[i]);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // Every hundred items each side decides afresh whether it idles, so
      // the run holds stretches with and without gaps.
      if (i % 100 == 0) begin
        src_idle_on  = $urandom_range(0, 3) != 0;
        sink_idle_on = $urandom_range(0, 3) != 0;
      end
      // Long receiver hold-off while the sender keeps offering samples.
      if (i == HOLD_AT) begin
        src_idle_on  = 1'b0;
        hold_request = 1'b1;
      end
      // Sender pause until the pipeline is empty.
      if (i == DRAIN_AT) drain_results();
      // Closing stretch at full rate on both sides.
      if (i >= QUIET_FROM) begin
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
      end
      send_sample(pick_sample());
    end

    drain_results();
    // Wait on to catch any result the unit sends unasked.
    repeat (10) @(posedge clk_i);

    if (sb.pending_q.size() != 0) begin
      sb.mismatches++;
      $display("%0.3f ns: results missing, expected %0d more, actual 0",
               $realtime, sb.pending_q.size());
    end

    $display("Run covered %0d samples over %0d frames with %0d results checked.",
             sb.samples_seen, sb.samples_seen / FRAME_LEN, sb.results_seen);
    $display("Largest difference predicted %0d, largest threshold %0d.",
             sb.peak_diff, sb.peak_thr);
    if (sb.mismatches == 0) begin
      $display("frame_second_difference_threshold_unit test passed");
    end else begin
      $display("frame_second_difference_threshold_unit test failed");
    end
    $finish;
  end

  // Time limit far beyond the slowest correct run.
  initial begin : watchdog
    #2_000_000;
    $display("frame_second_difference_threshold_unit test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/fsdt_pkg.sv
src/fsdt_sample_if.sv
src/fsdt_frame_cell.sv
src/fsdt_window_cell.sv
src/frame_second_difference_threshold_unit.sv
sim/tb.sv
